// ----- sv/sim2col_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the sparse im2col address generator.
// Used by every module of the block; depends on nothing.
package sim2col_pkg;

	localparam int MAX_DIM      = 2048;
	localparam int MAX_KERNEL   = 8;
	localparam int STEP_MAX     = 8;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);

	// configuration register indexes
	localparam logic [3:0] REG_IMAGE_HEIGHT = 4'd0;
	localparam logic [3:0] REG_IMAGE_WIDTH  = 4'd1;
	localparam logic [3:0] REG_KERNEL_ROWS  = 4'd2;
	localparam logic [3:0] REG_KERNEL_COLS  = 4'd3;
	localparam logic [3:0] REG_PAD_ROWS     = 4'd4;
	localparam logic [3:0] REG_PAD_COLS     = 4'd5;
	localparam logic [3:0] REG_STEP_ROWS    = 4'd6;
	localparam logic [3:0] REG_STEP_COLS    = 4'd7;

	// clamped configuration as seen by the datapath
	typedef struct packed {
		logic [11:0] hgt;
		logic [11:0] wid;
		logic [3:0]  kr;
		logic [3:0]  kc;
		logic [2:0]  pr;
		logic [2:0]  pc;
		logic [3:0]  sr;
		logic [3:0]  sc;
		logic [6:0]  area;
	} cfg_t;

	// one classified item between front and back
	typedef struct packed {
		logic [31:0] row_base;   // (chan*H + h0)*W, modulo 2^32
		logic [15:0] h0;         // two's complement first tap row
		logic [15:0] w0;         // two's complement first tap column
		logic [15:0] mrow;       // chan*KH*KW, low 16 bits
		logic [21:0] pos;
	} task_t;

	typedef struct packed {
		logic [31:0] source_address;
		logic        in_bounds;
		logic [15:0] matrix_row;
		logic [21:0] matrix_col;
		logic        last_tap;
	} result_t;

	function automatic logic [11:0] clamp_dim(input logic [11:0] v);
		logic [11:0] r;
		begin
			if (v == 12'd0) r = 12'd1;
			else if (v > 12'(MAX_DIM)) r = 12'(MAX_DIM);
			else r = v;
			return r;
		end
	endfunction

	function automatic logic [3:0] clamp_kernel(input logic [3:0] v);
		logic [3:0] r;
		begin
			if (v == 4'd0) r = 4'd1;
			else if (v > 4'(MAX_KERNEL)) r = 4'(MAX_KERNEL);
			else r = v;
			return r;
		end
	endfunction

	function automatic logic [3:0] clamp_step(input logic [3:0] v);
		logic [3:0] r;
		begin
			if (v == 4'd0) r = 4'd1;
			else if (v > 4'(STEP_MAX)) r = 4'(STEP_MAX);
			else r = v;
			return r;
		end
	endfunction

endpackage

// ----- sv/sparse_im2col_address_gen.sv -----
`timescale 1ns / 1ps
// Sparse im2col address generator. A started item passes front stages 1 and 2, the
// queue and the back-end tap walker, which gives one result per cycle for each kernel
// tap of an item; further items queue up to 4 deep meanwhile.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset clears control state and restores the default configuration.
module sparse_im2col_address_gen import sim2col_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [11:0] cfg_data,
	// item command
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  in_channel,
	input  logic [21:0] position_index,
	input  logic [10:0] out_row,
	input  logic [10:0] out_col,
	// results
	output logic        result_valid,
	output logic [31:0] source_address,
	output logic        in_bounds,
	output logic [15:0] matrix_row,
	output logic [21:0] matrix_col,
	output logic        last_tap
);

	logic [11:0] hgt_q;
	logic [11:0] wid_q;
	logic [3:0]  kr_q;
	logic [3:0]  kc_q;
	logic [2:0]  pr_q;
	logic [2:0]  pc_q;
	logic [3:0]  sr_q;
	logic [3:0]  sc_q;

	cfg_t              cfg;
	logic              accept;
	logic [1:0]        inflight;
	logic              push;
	task_t             push_task;
	logic              pop;
	task_t             head;
	logic              nonempty;
	logic [QCNT_W-1:0] count;
	logic [QCNT_W:0]   occupancy;
	result_t           result;
	logic [7:0]        area_full;

	// Configuration writes are always taken; store the clamped value so the
	// datapath sees legal ranges only. Unknown indexes drop the transfer.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hgt_q <= 12'd32;
			wid_q <= 12'd32;
			kr_q  <= 4'd3;
			kc_q  <= 4'd3;
			pr_q  <= 3'd1;
			pc_q  <= 3'd1;
			sr_q  <= 4'd1;
			sc_q  <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_HEIGHT: hgt_q <= clamp_dim(cfg_data);
				REG_IMAGE_WIDTH:  wid_q <= clamp_dim(cfg_data);
				REG_KERNEL_ROWS:  kr_q  <= clamp_kernel(cfg_data[3:0]);
				REG_KERNEL_COLS:  kc_q  <= clamp_kernel(cfg_data[3:0]);
				REG_PAD_ROWS:     pr_q  <= cfg_data[2:0];
				REG_PAD_COLS:     pc_q  <= cfg_data[2:0];
				REG_STEP_ROWS:    sr_q  <= clamp_step(cfg_data[3:0]);
				REG_STEP_COLS:    sc_q  <= clamp_step(cfg_data[3:0]);
				default: ;
			endcase
		end
	end

	// kernel area fits in 7 bits (at most 64 taps)
	assign area_full = {4'b0, kr_q} * {4'b0, kc_q};

	always_comb begin
		cfg.hgt  = hgt_q;
		cfg.wid  = wid_q;
		cfg.kr   = kr_q;
		cfg.kc   = kc_q;
		cfg.pr   = pr_q;
		cfg.pc   = pc_q;
		cfg.sr   = sr_q;
		cfg.sc   = sc_q;
		cfg.area = area_full[6:0];
	end

	// Hold off new items once the queue plus the front stages could fill it.
	assign occupancy = {1'b0, count} + {{(QCNT_W - 1){1'b0}}, inflight};
	assign busy      = (occupancy >= (QCNT_W + 1)'(QDEPTH));
	assign accept    = start && !busy;

	sim2col_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.accept         (accept),
		.in_channel     (in_channel),
		.position_index (position_index),
		.out_row        (out_row),
		.out_col        (out_col),
		.inflight       (inflight),
		.push           (push),
		.push_task      (push_task)
	);

	sim2col_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_task (push_task),
		.pop       (pop),
		.head      (head),
		.nonempty  (nonempty),
		.count     (count)
	);

	sim2col_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.nonempty (nonempty),
		.head     (head),
		.pop      (pop),
		.strobe   (result_valid),
		.result   (result)
	);

	assign source_address = result.source_address;
	assign in_bounds      = result.in_bounds;
	assign matrix_row     = result.matrix_row;
	assign matrix_col     = result.matrix_col;
	assign last_tap       = result.last_tap;

endmodule

// ----- sv/sim2col_front.sv -----
`timescale 1ns / 1ps
// Front end: takes accepted items and works out per-item bases in two stages.
// Depends on sim2col_pkg.
module sim2col_front import sim2col_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        accept,
	input  logic [9:0]  in_channel,
	input  logic [21:0] position_index,
	input  logic [10:0] out_row,
	input  logic [10:0] out_col,
	output logic [1:0]  inflight,
	output logic        push,
	output task_t       push_task
);

	logic        valid_s1;
	logic [21:0] chan_hgt_s1;
	logic [15:0] h0_s1;
	logic [15:0] w0_s1;
	logic [15:0] mrow_s1;
	logic [21:0] pos_s1;

	logic        valid_s2;
	task_t       task_s2;

	logic [14:0] rprod;
	logic [14:0] cprod;
	logic [31:0] rowsum;

	assign rprod  = {4'b0, out_row} * {11'b0, cfg.sr};
	assign cprod  = {4'b0, out_col} * {11'b0, cfg.sc};
	assign rowsum = {10'b0, chan_hgt_s1} + {{16{h0_s1[15]}}, h0_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: products against the configuration
	always_ff @(posedge clk) begin
		if (accept) begin
			chan_hgt_s1 <= {12'b0, in_channel} * {10'b0, cfg.hgt};
			h0_s1       <= {1'b0, rprod} - {13'b0, cfg.pr};
			w0_s1       <= {1'b0, cprod} - {13'b0, cfg.pc};
			mrow_s1     <= {6'b0, in_channel} * {9'b0, cfg.area};
			pos_s1      <= position_index;
		end
	end

	// stage 2: scale the first tap row by the image width
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			task_s2.row_base <= rowsum * {20'b0, cfg.wid};
			task_s2.h0       <= h0_s1;
			task_s2.w0       <= w0_s1;
			task_s2.mrow     <= mrow_s1;
			task_s2.pos      <= pos_s1;
		end
	end

	assign inflight  = {1'b0, valid_s1} + {1'b0, valid_s2};
	assign push      = valid_s2;
	assign push_task = task_s2;

endmodule

// ----- sv/sim2col_queue.sv -----
`timescale 1ns / 1ps
// Short FIFO of classified items between the front and back ends.
// Depends on sim2col_pkg.
module sim2col_queue import sim2col_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  task_t             push_task,
	input  logic              pop,
	output task_t             head,
	output logic              nonempty,
	output logic [QCNT_W-1:0] count
);

	task_t             entries [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries[wr_ptr_q] <= push_task;
	end

	assign head     = entries[rd_ptr_q];
	assign nonempty = (count_q != '0);
	assign count    = count_q;

endmodule

// ----- sv/sim2col_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the kernel taps of one item a cycle at a time, registered result.
// Depends on sim2col_pkg.
module sim2col_back import sim2col_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    nonempty,
	input  task_t   head,
	output logic    pop,
	output logic    strobe,
	output result_t result
);

	logic        active_q;
	logic [2:0]  i_q;
	logic [2:0]  j_q;
	logic [15:0] h_q;
	logic [15:0] w_q;
	logic [15:0] w0_q;
	logic [31:0] row_addr_q;
	logic [31:0] addr_q;
	logic [15:0] mrow_q;
	logic [21:0] pos_q;

	logic        strobe_q;
	result_t     result_q;

	logic [3:0]  kr_m1;
	logic [3:0]  kc_m1;
	logic        row_end;
	logic        last;
	logic        ok;
	logic [31:0] head_addr;
	logic [31:0] next_row_addr;

	assign kr_m1    = cfg.kr - 4'd1;
	assign kc_m1    = cfg.kc - 4'd1;
	assign row_end  = (j_q == kc_m1[2:0]);
	assign last     = row_end && (i_q == kr_m1[2:0]);
	assign pop      = nonempty && (!active_q || last);
	assign head_addr     = head.row_base + {{16{head.w0[15]}}, head.w0};
	assign next_row_addr = row_addr_q + {20'b0, cfg.wid};

	assign ok = !h_q[15] && !w_q[15]
		&& (h_q[14:0] < {3'b0, cfg.hgt}) && (w_q[14:0] < {3'b0, cfg.wid});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) active_q <= 1'b1;
			else if (last) active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			// load the next item at its first tap
			i_q        <= 3'd0;
			j_q        <= 3'd0;
			h_q        <= head.h0;
			w_q        <= head.w0;
			w0_q       <= head.w0;
			row_addr_q <= head_addr;
			addr_q     <= head_addr;
			mrow_q     <= head.mrow;
			pos_q      <= head.pos;
		end else if (active_q) begin
			mrow_q <= mrow_q + 16'd1;
			if (row_end) begin
				// wrap to the start of the next tap row
				i_q        <= i_q + 3'd1;
				j_q        <= 3'd0;
				h_q        <= h_q + 16'd1;
				w_q        <= w0_q;
				row_addr_q <= next_row_addr;
				addr_q     <= next_row_addr;
			end else begin
				j_q    <= j_q + 3'd1;
				w_q    <= w_q + 16'd1;
				addr_q <= addr_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			result_q.source_address <= ok ? addr_q : 32'd0;
			result_q.in_bounds      <= ok;
			result_q.matrix_row     <= mrow_q;
			result_q.matrix_col     <= pos_q;
			result_q.last_tap       <= last;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule
